### sv/r3d_pkg.sv
// ----------------------------------------------------------------------------
// r3d_pkg
// Shared types, widths and constants for the 3D point rotation block.
// ----------------------------------------------------------------------------
package r3d_pkg;

    // Data widths
    localparam int COORD_WIDTH  = 32;              // Q16.16 coordinates
    localparam int ANGLE_WIDTH  = 16;              // angle register width
    localparam int FRAC_W       = 16;              // fraction bits of Q16.16 and Q1.16
    localparam int COEF_W       = FRAC_W + 2;      // Q1.16 sine / cosine, two's complement
    localparam int PROD_W       = COEF_W + COORD_WIDTH;
    localparam int SUM_W        = PROD_W + 1;
    localparam int RND_W        = SUM_W - FRAC_W;  // rounded sum before saturation

    // Phase and CORDIC
    localparam int PHASE_W      = 16;              // 16384 is a quarter turn
    localparam int RES_W        = PHASE_W - 2;     // residue inside one quadrant
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 33;              // Q2.30 working values plus headroom
    localparam int ZACC_W       = RES_W + 3;       // angle accumulator
    localparam int CORDIC_SHR   = 30 - FRAC_W;     // Q2.30 down to Q1.16
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << FRAC_W);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ANGLE_WIDTH;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 1'd1;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
        logic signed [COORD_WIDTH-1:0] z_in;
        logic                          last_vertex;
    } vtx_word_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic signed [COORD_WIDTH-1:0] z_out;
        logic                          last_out;
    } res_word_t;

    // Trig unit status toward the datapath
    typedef struct packed {
        logic                     busy;
        logic signed [COEF_W-1:0] cos_v;
        logic signed [COEF_W-1:0] sin_v;
    } trig_t;

    // Per-stage load strobes for the multiply / round / saturate lanes
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } stage_ld_t;

    // atan(2^-i) in units of a quarter turn / 16384
    function automatic logic [RES_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic [RES_W-1:0] v;
        case (i)
            4'd0:    v = RES_W'(8192);
            4'd1:    v = RES_W'(4836);
            4'd2:    v = RES_W'(2555);
            4'd3:    v = RES_W'(1297);
            4'd4:    v = RES_W'(651);
            4'd5:    v = RES_W'(326);
            4'd6:    v = RES_W'(163);
            4'd7:    v = RES_W'(81);
            4'd8:    v = RES_W'(41);
            4'd9:    v = RES_W'(20);
            4'd10:   v = RES_W'(10);
            4'd11:   v = RES_W'(5);
            4'd12:   v = RES_W'(3);
            4'd13:   v = RES_W'(1);
            4'd14:   v = RES_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/r3d_cordic.sv
// ----------------------------------------------------------------------------
// r3d_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then
// rounding, clamping and quadrant fold into the held sine / cosine.
// ----------------------------------------------------------------------------
module r3d_cordic
    import r3d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ANGLE_WIDTH-1:0] angle,
    output trig_t                  trig
);

    logic [ANGLE_WIDTH+PHASE_W-1:0] ang_ext;
    logic [PHASE_W-1:0]             phase;

    logic                           busy_reg, busy_next;
    logic                           fin_reg, fin_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic signed [COEF_W-1:0]       cos_reg, cos_next;
    logic signed [COEF_W-1:0]       sin_reg, sin_next;

    logic signed [CORDIC_W-1:0]     x_reg, x_next;
    logic signed [CORDIC_W-1:0]     y_reg, y_next;
    logic signed [ZACC_W-1:0]       z_reg, z_next;
    logic [1:0]                     quad_reg;
    logic                           rzero_reg;

    logic signed [CORDIC_W-1:0]     dx, dy;
    logic signed [ZACC_W-1:0]       dz;
    logic signed [COEF_W-1:0]       c_q, s_q;

    function automatic logic signed [COEF_W-1:0] to_q16(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0]          t;
        logic signed [CORDIC_W-CORDIC_SHR-1:0] q;
        t = v + CORDIC_W'(1 << (CORDIC_SHR - 1));
        q = t[CORDIC_W-1:CORDIC_SHR];
        if (q > (CORDIC_W-CORDIC_SHR)'(COEF_ONE))
        begin
            return COEF_ONE;
        end
        if (q < -((CORDIC_W-CORDIC_SHR)'(COEF_ONE)))
        begin
            return -COEF_ONE;
        end
        return q[COEF_W-1:0];
    endfunction

    // Bring the angle to a 16-bit phase: top bits kept, zeros fill below
    assign ang_ext = {angle, PHASE_W'(0)};
    assign phase   = ang_ext[ANGLE_WIDTH+PHASE_W-1 -: PHASE_W];

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign dz = ZACC_W'(atan_lut(step_reg));

    always_comb
    begin
        if (z_reg >= 0)
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - dz;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + dz;
        end
    end

    always_comb
    begin
        if (rzero_reg)
        begin
            c_q = COEF_ONE;
            s_q = COEF_ZERO;
        end
        else
        begin
            c_q = to_q16(x_reg);
            s_q = to_q16(y_reg);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        step_next = step_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        if (start)
        begin
            busy_next = 1'b1;
            fin_next  = 1'b0;
            step_next = '0;
        end
        else if (fin_reg)
        begin
            busy_next = 1'b0;
            fin_next  = 1'b0;
            case (quad_reg)
                QUAD_0:
                begin
                    cos_next = c_q;
                    sin_next = s_q;
                end
                QUAD_1:
                begin
                    cos_next = -s_q;
                    sin_next = c_q;
                end
                QUAD_2:
                begin
                    cos_next = -c_q;
                    sin_next = -s_q;
                end
                default:
                begin
                    cos_next = s_q;
                    sin_next = -c_q;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                fin_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
            cos_reg  <= COEF_ONE;
            sin_reg  <= COEF_ZERO;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            step_reg <= step_next;
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg     <= CORDIC_GAIN;
            y_reg     <= '0;
            z_reg     <= ZACC_W'(phase[RES_W-1:0]);
            quad_reg  <= phase[PHASE_W-1 -: 2];
            rzero_reg <= (phase[RES_W-1:0] == '0);
        end
        else if (busy_reg && !fin_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign trig.busy  = busy_reg;
    assign trig.cos_v = cos_reg;
    assign trig.sin_v = sin_reg;

endmodule

### sv/r3d_lane.sv
// ----------------------------------------------------------------------------
// r3d_lane
// One output coordinate: two products, sum with rounding, saturation.
// ----------------------------------------------------------------------------
module r3d_lane
    import r3d_pkg::*;
(
    input  logic                          clk,
    input  stage_ld_t                     ld,
    input  logic signed [COEF_W-1:0]      coef_a,
    input  logic signed [COORD_WIDTH-1:0] opnd_a,
    input  logic signed [COEF_W-1:0]      coef_b,
    input  logic signed [COORD_WIDTH-1:0] opnd_b,
    output logic signed [COORD_WIDTH-1:0] result
);

    localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0]      pa_reg, pb_reg;
    logic signed [SUM_W-1:0]       sum;
    logic signed [RND_W-1:0]       rnd_reg;
    logic signed [COORD_WIDTH-1:0] sat_next;
    logic signed [COORD_WIDTH-1:0] res_reg;

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (ld.ld2)
        begin
            pa_reg <= PROD_W'(coef_a) * PROD_W'(opnd_a);
            pb_reg <= PROD_W'(coef_b) * PROD_W'(opnd_b);
        end
    end

    // stage 3: exact sum, round half up, drop fraction
    assign sum = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(1 << (FRAC_W - 1));

    always_ff @(posedge clk)
    begin
        if (ld.ld3)
        begin
            rnd_reg <= sum[SUM_W-1:FRAC_W];
        end
    end

    // stage 4: saturate when the upper bits disagree with the sign
    always_comb
    begin
        if (rnd_reg[RND_W-1:COORD_WIDTH-1] == '0 || rnd_reg[RND_W-1:COORD_WIDTH-1] == '1)
        begin
            sat_next = rnd_reg[COORD_WIDTH-1:0];
        end
        else if (rnd_reg[RND_W-1])
        begin
            sat_next = NEG_MIN;
        end
        else
        begin
            sat_next = POS_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld4)
        begin
            res_reg <= sat_next;
        end
    end

    assign result = res_reg;

endmodule

### sv/rotate_3d_point_about_axis.sv
// ----------------------------------------------------------------------------
// rotate_3d_point_about_axis
// Rotates Q16.16 vertices about X, Y or Z by a programmed angle.
//
//   channel   dir  handshake            word
//   vtx       in   vtx_valid/vtx_stall  vtx_word_t (x_in, y_in, z_in, last_vertex)
//   res       out  res_valid/res_stall  res_word_t (x_out, y_out, z_out, last_out)
//   cfg       in   cfg_wr               cfg_index, cfg_data (0 angle, 1 axis)
//
// One vertex per clock while vtx_stall is low; res_stall back-pressure and a
// busy trig unit raise it. A word passes the select, multiply, sum/round and
// saturate stages in order, then raises res_valid. An angle write makes the
// trig unit busy (16 micro-rotations, then fold and write-back of sin/cos).
// Reset: angle 0 (cos 1.0, sin 0), axis Y, pipeline empty.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up under res_stall and no word is dropped or repeated.
// ----------------------------------------------------------------------------
module rotate_3d_point_about_axis
    import r3d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  vtx_valid,
    output logic                  vtx_stall,
    input  vtx_word_t             vtx_word,

    output logic                  res_valid,
    input  logic                  res_stall,
    output res_word_t             res_word,

    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LANES = 3;

    trig_t                         trig;
    stage_ld_t                     ld;
    logic                          angle_wr;

    logic [1:0]                    axis_reg;

    // stage valid bits and the last-vertex flag that rides along
    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic                          l1_reg, l2_reg, l3_reg, l4_reg;
    logic                          rdy1, rdy2, rdy3, rdy4;
    logic                          vtx_acc;

    // stage 1: operands picked per output lane
    logic signed [COEF_W-1:0]      ca_next [LANES];
    logic signed [COEF_W-1:0]      cb_next [LANES];
    logic signed [COORD_WIDTH-1:0] oa_next [LANES];
    logic signed [COORD_WIDTH-1:0] ob_next [LANES];
    logic signed [COEF_W-1:0]      ca_reg  [LANES];
    logic signed [COEF_W-1:0]      cb_reg  [LANES];
    logic signed [COORD_WIDTH-1:0] oa_reg  [LANES];
    logic signed [COORD_WIDTH-1:0] ob_reg  [LANES];
    logic signed [COORD_WIDTH-1:0] lane_res [LANES];

    logic signed [COEF_W-1:0]      c_v, s_v, ns_v;

    // ---------------- configuration ----------------
    assign angle_wr = cfg_wr && (cfg_index == REG_ANGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_Y;
        end
        else if (cfg_wr && (cfg_index == REG_AXIS))
        begin
            axis_reg <= cfg_data[1:0];
        end
    end

    r3d_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (angle_wr),
        .angle (cfg_data[ANGLE_WIDTH-1:0]),
        .trig  (trig)
    );

    // ---------------- flow control ----------------
    assign rdy4 = !v4_reg || !res_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign vtx_stall = !rdy1 || trig.busy;
    assign vtx_acc   = vtx_valid && !vtx_stall;

    assign ld.ld2 = rdy2;
    assign ld.ld3 = rdy3;
    assign ld.ld4 = rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= vtx_acc;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ---------------- stage 1: rotation row select ----------------
    // Lanes: 0 -> x_out, 1 -> y_out, 2 -> z_out. Each lane is
    // coef_a*opnd_a + coef_b*opnd_b; an untouched coordinate is 1.0*v + 0.
    assign c_v  = trig.cos_v;
    assign s_v  = trig.sin_v;
    assign ns_v = -trig.sin_v;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            cb_next[k] = COEF_ZERO;
            ob_next[k] = '0;
        end
        ca_next[0] = COEF_ONE;
        oa_next[0] = vtx_word.x_in;
        ca_next[1] = COEF_ONE;
        oa_next[1] = vtx_word.y_in;
        ca_next[2] = COEF_ONE;
        oa_next[2] = vtx_word.z_in;
        case (axis_reg)
            AXIS_X:
            begin
                ca_next[1] = c_v;  oa_next[1] = vtx_word.y_in;
                cb_next[1] = ns_v; ob_next[1] = vtx_word.z_in;
                ca_next[2] = s_v;  oa_next[2] = vtx_word.y_in;
                cb_next[2] = c_v;  ob_next[2] = vtx_word.z_in;
            end
            AXIS_Y:
            begin
                ca_next[0] = c_v;  oa_next[0] = vtx_word.x_in;
                cb_next[0] = s_v;  ob_next[0] = vtx_word.z_in;
                ca_next[2] = c_v;  oa_next[2] = vtx_word.z_in;
                cb_next[2] = ns_v; ob_next[2] = vtx_word.x_in;
            end
            AXIS_Z:
            begin
                ca_next[0] = c_v;  oa_next[0] = vtx_word.x_in;
                cb_next[0] = ns_v; ob_next[0] = vtx_word.y_in;
                ca_next[1] = s_v;  oa_next[1] = vtx_word.x_in;
                cb_next[1] = c_v;  ob_next[1] = vtx_word.y_in;
            end
            default:
            begin
                // unused axis code: identity on all three
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                ca_reg[k] <= ca_next[k];
                cb_reg[k] <= cb_next[k];
                oa_reg[k] <= oa_next[k];
                ob_reg[k] <= ob_next[k];
            end
            l1_reg <= vtx_word.last_vertex;
        end
        if (rdy2)
        begin
            l2_reg <= l1_reg;
        end
        if (rdy3)
        begin
            l3_reg <= l2_reg;
        end
        if (rdy4)
        begin
            l4_reg <= l3_reg;
        end
    end

    // ---------------- stages 2..4: multiply, round, saturate ----------------
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        r3d_lane u_lane (
            .clk    (clk),
            .ld     (ld),
            .coef_a (ca_reg[g]),
            .opnd_a (oa_reg[g]),
            .coef_b (cb_reg[g]),
            .opnd_b (ob_reg[g]),
            .result (lane_res[g])
        );
    end

    assign res_valid         = v4_reg;
    assign res_word.x_out    = lane_res[0];
    assign res_word.y_out    = lane_res[1];
    assign res_word.z_out    = lane_res[2];
    assign res_word.last_out = l4_reg;

    // ---------------- assertions ----------------
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(vtx_acc && trig.busy))
        else $error("vertex taken while trig unit busy");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_acc |=> v1_reg)
        else $error("accepted vertex missing from stage 1");

    a_angle_starts_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        angle_wr |=> trig.busy)
        else $error("angle write did not start trig unit");

    a_s3_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy4) |=> v3_reg)
        else $error("stage 3 word lost under stall");

endmodule
